// ===== rtl/bmft_pkg.sv =====
// ----------------------------------------------------------------------------
// bmft_pkg: shared types and constants of the battery monitor frame tracker
// Holds field widths, frame identifier decode constants, fault masks, the
// result class and pack state codes, and the command passed front to back.
// ----------------------------------------------------------------------------
package bmft_pkg;

  localparam int ID_W       = 16;
  localparam int DATA_W     = 64;
  localparam int CODE_W     = 16;
  localparam int THR_W      = 16;
  localparam int SCALE_W    = 20;
  localparam int SFID_W     = 13;
  localparam int MV_W       = 20;
  localparam int TOTAL_W    = 32;
  localparam int CNT_W      = 16;
  localparam int PROD_W     = CODE_W + SCALE_W;
  localparam int FLT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int NIB_W      = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ID_W-1:0] ID_LOW        = 16'h1100;
  localparam logic [ID_W-1:0] ID_HIGH       = 16'h14FF;
  localparam logic [ID_W-1:0] CELL_BASE     = 16'h1100;
  localparam logic [ID_W-1:0] TEMP_BASE     = 16'h1200;
  localparam logic [ID_W-1:0] CELL_SEL_MASK = 16'hFF00;
  localparam logic [ID_W-1:0] TEMP_SEL_MASK = 16'hFFF0;

  localparam logic [FLT_W-1:0] SENSOR_FAULT_MASK = 8'h1E;
  localparam logic [FLT_W-1:0] NOT_OK_MASK       = 8'h01;
  localparam logic [FLT_W-1:0] OVER_TEMP_MASK    = 8'h04;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd100;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd6554;
  localparam logic [SFID_W-1:0]  SFID_RESET  = 13'h1300;

  typedef enum logic [2:0] {
    CLS_IGNORED = 3'd0,
    CLS_CELL    = 3'd1,
    CLS_TEMP    = 3'd2,
    CLS_STATUS  = 3'd3,
    CLS_TICK    = 3'd4
  } item_class_e;

  typedef enum logic [1:0] {
    PACK_NORMAL       = 2'd0,
    PACK_SENSOR_FAULT = 2'd1,
    PACK_FAULT        = 2'd2
  } pack_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SCALE     = 2'd1,
    CFG_STATUS_ID = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    item_class_e             cls;
    logic [NIB_W-1:0]        ic;
    logic [NIB_W-1:0]        grp;
    logic [DATA_W-1:0]       data;
  } cmd_t;

endpackage

// ===== rtl/bmft_if.sv =====
// ----------------------------------------------------------------------------
// bmft_if: request and result channels of the frame tracker
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface bmft_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [bmft_pkg::ID_W-1:0]   frame_id;
  logic [bmft_pkg::DATA_W-1:0] frame_data;

  modport source (output valid, kind, frame_id, frame_data, input ready);
  modport sink   (input valid, kind, frame_id, frame_data, output ready);
endinterface

interface bmft_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   item_class;
  logic [1:0]                   pack_state;
  logic                         lost_flag;
  logic                         over_temp_flag;
  logic                         any_fault_flag;
  logic [bmft_pkg::TOTAL_W-1:0] pack_total_mv;
  logic [bmft_pkg::FLT_W-1:0]   fault_bits_out;
  logic [bmft_pkg::FLT_W-1:0]   balance_mask_out;
  logic [bmft_pkg::MV_W-1:0]    min_cell_mv;
  logic [bmft_pkg::MV_W-1:0]    max_cell_mv;

  modport source (output valid, item_class, pack_state, lost_flag, over_temp_flag,
                  any_fault_flag, pack_total_mv, fault_bits_out, balance_mask_out,
                  min_cell_mv, max_cell_mv, input ready);
  modport sink   (input valid, item_class, pack_state, lost_flag, over_temp_flag,
                  any_fault_flag, pack_total_mv, fault_bits_out, balance_mask_out,
                  min_cell_mv, max_cell_mv, output ready);
endinterface

// ===== rtl/battery_monitor_frame_tracker_core.sv =====
// ----------------------------------------------------------------------------
// battery_monitor_frame_tracker_core: CAN battery monitor frame tracker
// Classifies received frames and periodic ticks and keeps pack status.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Requests enter a two-entry queue and
// the executor takes one at a time once the previous result has been taken.
// Ignored, cell and temperature frames finish in the cycle after leaving the
// queue, a status frame after two products on the shared 16x20 multiplier.
// A tick walks every stored cell through a read, multiply and accumulate
// pipeline at one cell per cycle. Cell codes live in a memory of one row per
// cell frame, with a valid bit per row so the store reads as zero after reset
// without a clearing pass.
// Configuration registers may be written only while no request is in flight.
module battery_monitor_frame_tracker_core #(
  parameter int MONITOR_COUNT     = 8,
  parameter int CELLS_PER_MONITOR = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bmft_in_if.sink                           req_i,
  bmft_out_if.source                        rsp_o,
  input  logic                              cfg_we_i,
  input  logic [bmft_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bmft_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic [bmft_pkg::THR_W-1:0]   thr_q;
  logic [bmft_pkg::SCALE_W-1:0] scale_q;
  logic [bmft_pkg::SFID_W-1:0]  sfid_q;

  logic            q_push, q_full, q_pop, q_empty;
  bmft_pkg::cmd_t  front_cmd, queue_cmd;
  bmft_pkg::item_class_e back_cls;
  bmft_pkg::pack_state_e back_pstate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= bmft_pkg::THR_RESET;
      scale_q <= bmft_pkg::SCALE_RESET;
      sfid_q  <= bmft_pkg::SFID_RESET;
    end else if (cfg_we_i) begin
      unique case (bmft_pkg::cfg_idx_e'(cfg_idx_i))
        bmft_pkg::CFG_THRESHOLD: thr_q   <= cfg_wdata_i[bmft_pkg::THR_W-1:0];
        bmft_pkg::CFG_SCALE:     scale_q <= cfg_wdata_i[bmft_pkg::SCALE_W-1:0];
        bmft_pkg::CFG_STATUS_ID: sfid_q  <= cfg_wdata_i[bmft_pkg::SFID_W-1:0];
        default: ;
      endcase
    end
  end

  bmft_front #(
    .MONITOR_COUNT (MONITOR_COUNT)
  ) u_front (
    .valid_i      (req_i.valid),
    .ready_o      (req_i.ready),
    .kind_i       (req_i.kind),
    .frame_id_i   (req_i.frame_id),
    .frame_data_i (req_i.frame_data),
    .sfid_i       (sfid_q),
    .full_i       (q_full),
    .push_o       (q_push),
    .cmd_o        (front_cmd)
  );

  bmft_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (queue_cmd),
    .empty_o (q_empty)
  );

  bmft_back #(
    .MONITOR_COUNT     (MONITOR_COUNT),
    .CELLS_PER_MONITOR (CELLS_PER_MONITOR)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .thr_i            (thr_q),
    .scale_i          (scale_q),
    .cmd_i            (queue_cmd),
    .cmd_valid_i      (!q_empty),
    .pop_o            (q_pop),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .item_class_o     (back_cls),
    .pack_state_o     (back_pstate),
    .lost_flag_o      (rsp_o.lost_flag),
    .over_temp_flag_o (rsp_o.over_temp_flag),
    .any_fault_flag_o (rsp_o.any_fault_flag),
    .pack_total_mv_o  (rsp_o.pack_total_mv),
    .fault_bits_o     (rsp_o.fault_bits_out),
    .balance_mask_o   (rsp_o.balance_mask_out),
    .min_cell_mv_o    (rsp_o.min_cell_mv),
    .max_cell_mv_o    (rsp_o.max_cell_mv)
  );

  assign rsp_o.item_class = back_cls;
  assign rsp_o.pack_state = back_pstate;

  a_pop_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !rsp_o.valid)
    else $error("command taken while a result is still pending");

  a_push_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> !q_empty)
    else $error("queue empty right after a request was pushed");

  a_over_temp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pstate != bmft_pkg::PACK_SENSOR_FAULT |-> !rsp_o.over_temp_flag)
    else $error("over temperature flagged outside sensor fault state");

  a_fault_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_pstate != bmft_pkg::PACK_NORMAL || rsp_o.lost_flag) |-> rsp_o.any_fault_flag)
    else $error("fault state or lost signal without any fault flag");

endmodule

// ===== rtl/bmft_front.sv =====
// ----------------------------------------------------------------------------
// bmft_front: request intake and frame classification
// Decodes the frame identifier into a command and pushes it into the queue.
// ----------------------------------------------------------------------------
module bmft_front #(
  parameter int MONITOR_COUNT = 8
) (
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          kind_i,
  input  logic [bmft_pkg::ID_W-1:0]     frame_id_i,
  input  logic [bmft_pkg::DATA_W-1:0]   frame_data_i,
  input  logic [bmft_pkg::SFID_W-1:0]   sfid_i,
  input  logic                          full_i,
  output logic                          push_o,
  output bmft_pkg::cmd_t                cmd_o
);

  logic in_range;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    in_range      = (frame_id_i >= bmft_pkg::ID_LOW) && (frame_id_i <= bmft_pkg::ID_HIGH);
    cmd_o.cls     = bmft_pkg::CLS_IGNORED;
    cmd_o.ic      = frame_id_i[7:4];
    cmd_o.grp     = frame_id_i[3:0];
    cmd_o.data    = frame_data_i;
    if (kind_i) begin
      cmd_o.cls = bmft_pkg::CLS_TICK;
    end else if (in_range) begin
      // cell test wins over temperature, which wins over the status id
      priority if ((frame_id_i & bmft_pkg::CELL_SEL_MASK) == bmft_pkg::CELL_BASE) begin
        if (32'(frame_id_i[7:4]) < MONITOR_COUNT) begin
          cmd_o.cls = bmft_pkg::CLS_CELL;
        end
      end else if ((frame_id_i & bmft_pkg::TEMP_SEL_MASK) == bmft_pkg::TEMP_BASE) begin
        cmd_o.ic = frame_id_i[3:0];
        if (32'(frame_id_i[3:0]) < MONITOR_COUNT) begin
          cmd_o.cls = bmft_pkg::CLS_TEMP;
        end
      end else if (frame_id_i == {3'b000, sfid_i}) begin
        cmd_o.cls = bmft_pkg::CLS_STATUS;
      end else begin
        cmd_o.cls = bmft_pkg::CLS_IGNORED;
      end
    end
  end

endmodule

// ===== rtl/bmft_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// bmft_cmd_queue: two-entry command queue between front and back
// Lets the intake keep taking requests while the back end is busy.
// ----------------------------------------------------------------------------
module bmft_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bmft_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output bmft_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  bmft_pkg::cmd_t ent_q [bmft_pkg::QUEUE_DEPTH];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(bmft_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = ent_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = pop_i ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/bmft_back.sv =====
// ----------------------------------------------------------------------------
// bmft_back: command execution
// Owns the cell code memory, silence counters and pack status. A tick walks
// every cell through a read / multiply / accumulate pipeline, one per cycle.
// ----------------------------------------------------------------------------
module bmft_back #(
  parameter int MONITOR_COUNT     = 8,
  parameter int CELLS_PER_MONITOR = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bmft_pkg::THR_W-1:0]     thr_i,
  input  logic [bmft_pkg::SCALE_W-1:0]   scale_i,
  input  bmft_pkg::cmd_t                 cmd_i,
  input  logic                           cmd_valid_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmft_pkg::item_class_e          item_class_o,
  output bmft_pkg::pack_state_e          pack_state_o,
  output logic                           lost_flag_o,
  output logic                           over_temp_flag_o,
  output logic                           any_fault_flag_o,
  output logic [bmft_pkg::TOTAL_W-1:0]   pack_total_mv_o,
  output logic [bmft_pkg::FLT_W-1:0]     fault_bits_o,
  output logic [bmft_pkg::FLT_W-1:0]     balance_mask_o,
  output logic [bmft_pkg::MV_W-1:0]      min_cell_mv_o,
  output logic [bmft_pkg::MV_W-1:0]      max_cell_mv_o
);

  localparam int IW     = (MONITOR_COUNT > 1) ? $clog2(MONITOR_COUNT) : 1;
  localparam int CW     = (CELLS_PER_MONITOR > 1) ? $clog2(CELLS_PER_MONITOR) : 1;
  localparam int GROUPS = (CELLS_PER_MONITOR + 3) / 4;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int AW     = IW + GW;
  localparam int ROWS   = MONITOR_COUNT * (2 ** GW);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_STAT_LO = 5'b00010,
    S_STAT_HI = 5'b00100,
    S_WALK    = 5'b01000,
    S_DRAIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // memory rows hold the four codes of one cell frame
  logic [bmft_pkg::DATA_W-1:0] mem_q [ROWS];
  logic [bmft_pkg::DATA_W-1:0] rdata_q;
  logic [ROWS-1:0]             rvalid_q;

  logic [bmft_pkg::CNT_W-1:0]  silence_q [MONITOR_COUNT];
  logic [bmft_pkg::CNT_W-1:0]  inc [MONITOR_COUNT];
  logic [MONITOR_COUNT-1:0]    online_q;
  logic [MONITOR_COUNT-1:0]    online_d;

  bmft_pkg::cmd_t              cmd_q;
  logic [IW-1:0]               wic_q;
  logic [CW-1:0]               wcel_q;
  logic                        p1_q, p2_q;
  logic                        vld1_q;
  logic [1:0]                  lane1_q;
  logic [bmft_pkg::CODE_W-1:0] mul_a;
  logic [bmft_pkg::PROD_W-1:0] prod_q;
  logic [bmft_pkg::MV_W-1:0]   prod_mv;
  logic [bmft_pkg::TOTAL_W:0]  acc_sum;
  logic [bmft_pkg::TOTAL_W-1:0] acc_q;

  logic [bmft_pkg::FLT_W-1:0]  fault_q, bal_q;
  logic [bmft_pkg::MV_W-1:0]   min_q, max_q;
  logic [bmft_pkg::TOTAL_W-1:0] total_q;
  bmft_pkg::pack_state_e       pstate_q, pstate_d;
  logic                        lost_q, otemp_q, anyf_q;
  logic                        lost_c;
  logic                        out_valid_q;
  bmft_pkg::item_class_e       out_cls_q;

  logic                        is_tick, is_stat, is_clr, mem_we;
  logic                        walk_last, finish;
  logic [AW-1:0]               wr_addr, rd_addr;

  assign pop_o   = (state_q == S_IDLE) && cmd_valid_i && !out_valid_q;
  assign is_tick = pop_o && (cmd_i.cls == bmft_pkg::CLS_TICK);
  assign is_stat = pop_o && (cmd_i.cls == bmft_pkg::CLS_STATUS);
  assign is_clr  = pop_o && ((cmd_i.cls == bmft_pkg::CLS_CELL) ||
                             (cmd_i.cls == bmft_pkg::CLS_TEMP));
  // groups past the end of a monitor are dropped
  assign mem_we  = pop_o && (cmd_i.cls == bmft_pkg::CLS_CELL) &&
                   (32'(cmd_i.grp) < GROUPS);
  assign wr_addr = {cmd_i.ic[IW-1:0], cmd_i.grp[GW-1:0]};
  assign rd_addr = {wic_q, GW'(wcel_q >> 2)};
  assign walk_last = (wcel_q == CW'(CELLS_PER_MONITOR - 1)) &&
                     (wic_q == IW'(MONITOR_COUNT - 1));
  assign finish  = (state_q == S_DRAIN) && !p1_q && !p2_q;
  assign prod_mv = prod_q[bmft_pkg::PROD_W-1:bmft_pkg::PROD_W-bmft_pkg::MV_W];
  assign acc_sum = {1'b0, acc_q} + (bmft_pkg::TOTAL_W+1)'(prod_mv);

  always_comb begin
    lost_c = 1'b0;
    for (int i = 0; i < MONITOR_COUNT; i++) begin
      inc[i]      = (silence_q[i] == '1) ? silence_q[i] : silence_q[i] + 1'b1;
      online_d[i] = (silence_q[i] <= thr_i);
      lost_c      = lost_c | (inc[i] > thr_i);
    end
  end

  always_comb begin
    priority if ((fault_q & bmft_pkg::SENSOR_FAULT_MASK) != '0) begin
      pstate_d = bmft_pkg::PACK_SENSOR_FAULT;
    end else if (lost_c) begin
      pstate_d = bmft_pkg::PACK_FAULT;
    end else if ((fault_q & bmft_pkg::NOT_OK_MASK) != '0) begin
      pstate_d = bmft_pkg::PACK_FAULT;
    end else begin
      pstate_d = bmft_pkg::PACK_NORMAL;
    end
  end

  // shared multiplier: walk pipeline, then status low and high codes
  always_comb begin
    if (p1_q) begin
      mul_a = vld1_q ? rdata_q[bmft_pkg::CODE_W*lane1_q +: bmft_pkg::CODE_W] : '0;
    end else if (state_q == S_STAT_LO) begin
      mul_a = cmd_q.data[63:48];
    end else begin
      mul_a = cmd_i.data[47:32];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_tick) begin
          state_d = S_WALK;
        end else if (is_stat) begin
          state_d = S_STAT_LO;
        end
      end
      S_STAT_LO: state_d = S_STAT_HI;
      S_STAT_HI: state_d = S_IDLE;
      S_WALK: begin
        if (walk_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= cmd_i.data;
    end
    rdata_q <= mem_q[rd_addr];
    lane1_q <= 2'(wcel_q);
    prod_q  <= bmft_pkg::PROD_W'(mul_a) * bmft_pkg::PROD_W'(scale_i);
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rvalid_q    <= '0;
      for (int i = 0; i < MONITOR_COUNT; i++) begin
        silence_q[i] <= '0;
      end
      online_q    <= '0;
      wic_q       <= '0;
      wcel_q      <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      vld1_q      <= 1'b0;
      acc_q       <= '0;
      fault_q     <= '0;
      bal_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      total_q     <= '0;
      pstate_q    <= bmft_pkg::PACK_NORMAL;
      lost_q      <= 1'b0;
      otemp_q     <= 1'b0;
      anyf_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_cls_q   <= bmft_pkg::CLS_IGNORED;
    end else begin
      state_q <= state_d;
      p1_q    <= (state_q == S_WALK);
      p2_q    <= p1_q;
      vld1_q  <= rvalid_q[rd_addr] && online_q[wic_q];

      if (mem_we) begin
        rvalid_q[wr_addr] <= 1'b1;
      end

      for (int i = 0; i < MONITOR_COUNT; i++) begin
        if (finish) begin
          silence_q[i] <= inc[i];
        end else if (is_clr && (cmd_i.ic[IW-1:0] == IW'(i))) begin
          silence_q[i] <= '0;
        end
      end

      if (is_tick) begin
        online_q <= online_d;
        wic_q    <= '0;
        wcel_q   <= '0;
        acc_q    <= '0;
      end else if (state_q == S_WALK) begin
        if (wcel_q == CW'(CELLS_PER_MONITOR - 1)) begin
          wcel_q <= '0;
          wic_q  <= wic_q + 1'b1;
        end else begin
          wcel_q <= wcel_q + 1'b1;
        end
      end

      if (p2_q) begin
        acc_q <= acc_sum[bmft_pkg::TOTAL_W] ? '1 : acc_sum[bmft_pkg::TOTAL_W-1:0];
      end

      if (is_stat) begin
        fault_q <= cmd_i.data[7:0];
        bal_q   <= cmd_i.data[15:8];
      end
      if (state_q == S_STAT_LO) begin
        min_q <= prod_mv;
      end
      if (state_q == S_STAT_HI) begin
        max_q <= prod_mv;
      end

      if (finish) begin
        total_q  <= acc_q;
        lost_q   <= lost_c;
        otemp_q  <= (fault_q & bmft_pkg::OVER_TEMP_MASK) != '0;
        anyf_q   <= (fault_q != '0) || lost_c;
        pstate_q <= pstate_d;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end else if ((pop_o && !is_tick && !is_stat) || (state_q == S_STAT_HI) ||
                   finish) begin
        out_valid_q <= 1'b1;
      end
      if (pop_o) begin
        out_cls_q <= cmd_i.cls;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_class_o     = out_cls_q;
  assign pack_state_o     = pstate_q;
  assign lost_flag_o      = lost_q;
  assign over_temp_flag_o = otemp_q;
  assign any_fault_flag_o = anyf_q;
  assign pack_total_mv_o  = total_q;
  assign fault_bits_o     = fault_q;
  assign balance_mask_o   = bal_q;
  assign min_cell_mv_o    = min_q;
  assign max_cell_mv_o    = max_q;

endmodule

// ===== test/bmft_pack_checker.sv =====
// ----------------------------------------------------------------------------
// bmft_pack_checker: pack status predictor and result checker
// Watches the request, result and register write ports of the frame tracker.
// Each accepted request updates a private copy of the pack state and queues
// the report that the block must give. Each accepted result is compared
// field by field with the oldest queued report.
// ----------------------------------------------------------------------------
module bmft_pack_checker #(
  parameter int MONITOR_COUNT     = 8,
  parameter int CELLS_PER_MONITOR = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bmft_in_if                                req_mon,
  bmft_out_if                               rsp_mon,
  input  logic                              cfg_we_i,
  input  logic [bmft_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bmft_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam int CELL_TOTAL = MONITOR_COUNT * CELLS_PER_MONITOR;

  typedef struct packed {
    bmft_pkg::item_class_e        cls;
    bmft_pkg::pack_state_e        state;
    logic                         lost;
    logic                         over_temp;
    logic                         any_fault;
    logic [bmft_pkg::TOTAL_W-1:0] total_mv;
    logic [bmft_pkg::FLT_W-1:0]   fault_byte;
    logic [bmft_pkg::FLT_W-1:0]   balance_mask;
    logic [bmft_pkg::MV_W-1:0]    min_mv;
    logic [bmft_pkg::MV_W-1:0]    max_mv;
  } pack_report_t;

  // register copies
  logic [bmft_pkg::THR_W-1:0]   quiet_limit;
  logic [bmft_pkg::SCALE_W-1:0] mv_per_code;
  logic [bmft_pkg::SFID_W-1:0]  status_id;

  // pack state copy
  logic [bmft_pkg::CODE_W-1:0]  cell_code_mem [CELL_TOTAL];
  logic [bmft_pkg::CNT_W-1:0]   quiet_cycles  [MONITOR_COUNT];
  logic [bmft_pkg::FLT_W-1:0]   fault_byte;
  logic [bmft_pkg::FLT_W-1:0]   balance_mask;
  logic [bmft_pkg::MV_W-1:0]    min_mv;
  logic [bmft_pkg::MV_W-1:0]    max_mv;
  logic [bmft_pkg::TOTAL_W-1:0] total_mv;
  bmft_pkg::pack_state_e        pack_state;
  logic                         lost;
  logic                         over_temp;
  logic                         any_fault;

  pack_report_t       expected_reports [$];
  int                 error_count;

  function automatic void clear_pack();
    quiet_limit  = bmft_pkg::THR_RESET;
    mv_per_code  = bmft_pkg::SCALE_RESET;
    status_id    = bmft_pkg::SFID_RESET;
    for (int i = 0; i < CELL_TOTAL; i++) cell_code_mem[i] = '0;
    for (int i = 0; i < MONITOR_COUNT; i++) quiet_cycles[i] = '0;
    fault_byte   = '0;
    balance_mask = '0;
    min_mv       = '0;
    max_mv       = '0;
    total_mv     = '0;
    pack_state   = bmft_pkg::PACK_NORMAL;
    lost         = 1'b0;
    over_temp    = 1'b0;
    any_fault    = 1'b0;
  endfunction

  // unsigned Q16 scaling, product truncated
  function automatic logic [bmft_pkg::MV_W-1:0] code_to_mv(logic [bmft_pkg::CODE_W-1:0] code);
    logic [bmft_pkg::PROD_W-1:0] prod;
    prod = bmft_pkg::PROD_W'(code) * bmft_pkg::PROD_W'(mv_per_code);
    return prod[bmft_pkg::PROD_W-1:16];
  endfunction

  function automatic void run_tick();
    longint unsigned sum;
    logic            silent;
    sum    = 0;
    silent = 1'b0;
    for (int m = 0; m < MONITOR_COUNT; m++) begin
      if (quiet_cycles[m] <= quiet_limit) begin
        for (int c = 0; c < CELLS_PER_MONITOR; c++) begin
          sum += code_to_mv(cell_code_mem[m*CELLS_PER_MONITOR + c]);
          if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        end
      end
    end
    total_mv = 32'(sum);
    for (int m = 0; m < MONITOR_COUNT; m++) begin
      if (quiet_cycles[m] != '1) quiet_cycles[m] = quiet_cycles[m] + 1'b1;
      if (quiet_cycles[m] > quiet_limit) silent = 1'b1;
    end
    lost      = silent;
    over_temp = |(fault_byte & bmft_pkg::OVER_TEMP_MASK);
    any_fault = (fault_byte != '0) || silent;
    // sensor faults win over a lost signal, which wins over a plain not-ok bit
    if (|(fault_byte & bmft_pkg::SENSOR_FAULT_MASK)) pack_state = bmft_pkg::PACK_SENSOR_FAULT;
    else if (silent) pack_state = bmft_pkg::PACK_FAULT;
    else if (|(fault_byte & bmft_pkg::NOT_OK_MASK)) pack_state = bmft_pkg::PACK_FAULT;
    else pack_state = bmft_pkg::PACK_NORMAL;
  endfunction

  function automatic bmft_pkg::item_class_e apply_frame(logic [bmft_pkg::ID_W-1:0] id,
                                                        logic [bmft_pkg::DATA_W-1:0] data);
    int unsigned mon;
    int unsigned slot;
    bmft_pkg::item_class_e cls;
    cls = bmft_pkg::CLS_IGNORED;
    if (id >= bmft_pkg::ID_LOW && id <= bmft_pkg::ID_HIGH) begin
      // cell and temperature decode come before the status id compare
      if ((id & bmft_pkg::CELL_SEL_MASK) == bmft_pkg::CELL_BASE) begin
        mon = id[7:4];
        if (mon < MONITOR_COUNT) begin
          quiet_cycles[mon] = '0;
          for (int k = 0; k < 4; k++) begin
            slot = id[3:0] * 4 + k;
            if (slot < CELLS_PER_MONITOR)
              cell_code_mem[mon*CELLS_PER_MONITOR + slot] = data[16*k +: 16];
          end
          cls = bmft_pkg::CLS_CELL;
        end
      end else if ((id & bmft_pkg::TEMP_SEL_MASK) == bmft_pkg::TEMP_BASE) begin
        mon = id[3:0];
        if (mon < MONITOR_COUNT) begin
          quiet_cycles[mon] = '0;
          cls = bmft_pkg::CLS_TEMP;
        end
      end else if (id == bmft_pkg::ID_W'(status_id)) begin
        fault_byte   = data[7:0];
        balance_mask = data[15:8];
        min_mv       = code_to_mv(data[47:32]);
        max_mv       = code_to_mv(data[63:48]);
        cls = bmft_pkg::CLS_STATUS;
      end
    end
    return cls;
  endfunction

  function automatic pack_report_t apply_request(logic kind, logic [bmft_pkg::ID_W-1:0] id,
                                                 logic [bmft_pkg::DATA_W-1:0] data);
    pack_report_t rep;
    if (kind) begin
      run_tick();
      rep.cls = bmft_pkg::CLS_TICK;
    end else begin
      rep.cls = apply_frame(id, data);
    end
    rep.state        = pack_state;
    rep.lost         = lost;
    rep.over_temp    = over_temp;
    rep.any_fault    = any_fault;
    rep.total_mv     = total_mv;
    rep.fault_byte   = fault_byte;
    rep.balance_mask = balance_mask;
    rep.min_mv       = min_mv;
    rep.max_mv       = max_mv;
    return rep;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pack_report_t want;
    if (!rst_ni) begin
      clear_pack();
      expected_reports.delete();
      error_count = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        unique case (bmft_pkg::cfg_idx_e'(cfg_idx_i))
          bmft_pkg::CFG_THRESHOLD: quiet_limit = cfg_wdata_i[bmft_pkg::THR_W-1:0];
          bmft_pkg::CFG_SCALE:     mv_per_code = cfg_wdata_i[bmft_pkg::SCALE_W-1:0];
          bmft_pkg::CFG_STATUS_ID: status_id   = cfg_wdata_i[bmft_pkg::SFID_W-1:0];
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual class %0h total %0h",
                   $time, rsp_mon.item_class, rsp_mon.pack_total_mv);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("item_class",     64'(want.cls),          64'(rsp_mon.item_class));
          check_field("pack_state",     64'(want.state),        64'(rsp_mon.pack_state));
          check_field("lost_flag",      64'(want.lost),         64'(rsp_mon.lost_flag));
          check_field("over_temp_flag", 64'(want.over_temp),    64'(rsp_mon.over_temp_flag));
          check_field("any_fault_flag", 64'(want.any_fault),    64'(rsp_mon.any_fault_flag));
          check_field("pack_total_mv",  64'(want.total_mv),     64'(rsp_mon.pack_total_mv));
          check_field("fault_byte",     64'(want.fault_byte),   64'(rsp_mon.fault_bits_out));
          check_field("balance_mask",   64'(want.balance_mask), 64'(rsp_mon.balance_mask_out));
          check_field("min_cell_mv",    64'(want.min_mv),       64'(rsp_mon.min_cell_mv));
          check_field("max_cell_mv",    64'(want.max_mv),       64'(rsp_mon.max_cell_mv));
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_reports.push_back(apply_request(req_mon.kind, req_mon.frame_id,
                                                 req_mon.frame_data));
      fail_count_o <= error_count;
      pending_o    <= expected_reports.size();
    end
  end

endmodule

// ===== test/battery_monitor_frame_tracker_core_test.sv =====
// ----------------------------------------------------------------------------
// battery_monitor_frame_tracker_core_test: frame tracker testbench top
// Drives frames and ticks into the tracker under several register settings
// and random stalls on both channels; a side checker predicts every report.
// ----------------------------------------------------------------------------
module battery_monitor_frame_tracker_core_test;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 140;
  localparam int HOLD_CYCLES  = 400;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [bmft_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [bmft_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              fail_count;
  int                              pending;

  int                              src_idle_pct;
  int                              sink_idle_pct;
  bit                              rx_hold_req;
  logic [bmft_pkg::ID_W-1:0]       status_id;

  bmft_in_if  req_if ();
  bmft_out_if rsp_if ();

  battery_monitor_frame_tracker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bmft_pack_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(logic kind, logic [bmft_pkg::ID_W-1:0] id,
                           logic [bmft_pkg::DATA_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.frame_id   <= id;
    req_if.frame_data <= data;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_tick();
    send_item(1'b1, bmft_pkg::ID_W'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_frame(logic [bmft_pkg::ID_W-1:0] id, logic [bmft_pkg::DATA_W-1:0] data);
    send_item(1'b0, id, data);
  endtask

  function automatic logic [bmft_pkg::FLT_W-1:0] pick_fault_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return '0;
    else if (r < 70) return bmft_pkg::FLT_W'(1) << $urandom_range(bmft_pkg::FLT_W-1);
    else return bmft_pkg::FLT_W'($urandom);
  endfunction

  // waits until every report is in, then rewrites all three registers
  task automatic reconfigure(logic [bmft_pkg::THR_W-1:0] thr,
                             logic [bmft_pkg::SCALE_W-1:0] scale,
                             logic [bmft_pkg::SFID_W-1:0] sfid);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= bmft_pkg::CFG_THRESHOLD;
    cfg_wdata <= bmft_pkg::CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_idx   <= bmft_pkg::CFG_SCALE;
    cfg_wdata <= bmft_pkg::CFG_DATA_W'(scale);
    @(posedge clk_i);
    cfg_idx   <= bmft_pkg::CFG_STATUS_ID;
    cfg_wdata <= bmft_pkg::CFG_DATA_W'(sfid);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    status_id = bmft_pkg::ID_W'(sfid);
  endtask

  task automatic send_random_item();
    int unsigned                pick;
    logic [3:0]                 mon;
    logic [3:0]                 grp;
    logic [bmft_pkg::DATA_W-1:0] data;
    pick = $urandom_range(99);
    data = {$urandom, $urandom};
    mon  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
    grp  = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 4)) : 4'($urandom_range(3));
    if (pick < 25) begin
      send_tick();
    end else if (pick < 55) begin
      send_frame(bmft_pkg::CELL_BASE | {8'h00, mon, grp}, data);
    end else if (pick < 65) begin
      send_frame(bmft_pkg::TEMP_BASE | {12'h000, mon}, data);
    end else if (pick < 75) begin
      data[7:0] = pick_fault_byte();
      send_frame(status_id, data);
    end else if (pick < 88) begin
      send_frame(bmft_pkg::ID_W'($urandom_range(int'(bmft_pkg::ID_HIGH),
                                                int'(bmft_pkg::ID_LOW))), data);
    end else begin
      send_frame(bmft_pkg::ID_W'($urandom), data);
    end
  endtask

  task automatic send_random_items(int count);
    repeat (count) send_random_item();
  endtask

  task automatic run_directed();
    send_tick();                                             // empty pack
    send_frame(16'h1100, '1);                                // monitor 0, full-scale codes
    send_frame(16'h1173, {$urandom, $urandom});              // last monitor, last group
    send_frame(16'h1134, {$urandom, $urandom});              // slots past the monitor
    send_frame(16'h1180, {$urandom, $urandom});              // monitor out of range
    send_frame(16'h11F0, '1);
    send_frame(16'h1207, '0);                                // temperature frame
    send_frame(16'h1208, '1);                                // temperature, bad monitor
    send_frame(16'h10FF, '1);                                // just below the range
    send_frame(16'h1500, '1);                                // just above the range
    send_frame(16'h14FF, '1);                                // in range, no match
    send_frame(16'h0000, '0);
    send_frame(16'hFFFF, '1);
    send_frame(status_id, {16'hFFFF, 16'h0000, 16'h1234, 8'hA5, 8'h04});  // over temp
    send_tick();
    send_frame(status_id, {16'h8000, 16'h0001, 16'hFFFF, 8'h5A, 8'h01});  // not ok
    send_tick();
    send_frame(status_id, {$urandom, $urandom} & ~64'hFF | 64'h10);       // sensor fault
    send_tick();
    send_frame(status_id, '1);
    send_tick();
    send_frame(status_id, {$urandom, $urandom} & ~64'hFF);                // all clear
    send_tick();
  endtask

  initial begin
    src_idle_pct      = 31;
    sink_idle_pct     = 81;
    rx_hold_req       = 1'b0;
    status_id         = bmft_pkg::ID_W'(bmft_pkg::SFID_RESET);
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= bmft_pkg::CFG_THRESHOLD;
    cfg_wdata         <= '0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= 1'b0;
    req_if.frame_id   <= '0;
    req_if.frame_data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    send_random_items(100);

    // every monitor drops out after one silent tick
    reconfigure('0, '1, bmft_pkg::SFID_W'(bmft_pkg::ID_HIGH));
    send_random_items(100);

    src_idle_pct  = 81;
    sink_idle_pct = 31;
    // status id shadowed by a cell frame id
    reconfigure(bmft_pkg::THR_W'(3), '0, bmft_pkg::SFID_W'(bmft_pkg::CELL_BASE));
    send_random_items(80);

    // status id shadowed by a temperature frame id
    reconfigure(bmft_pkg::THR_W'(65534), bmft_pkg::SCALE_RESET,
                bmft_pkg::SFID_W'(bmft_pkg::TEMP_BASE | 16'h0005));
    send_random_items(80);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    reconfigure(bmft_pkg::THR_W'($urandom_range(6, 1)), bmft_pkg::SCALE_W'($urandom),
                bmft_pkg::SFID_W'($urandom_range(int'(bmft_pkg::ID_HIGH),
                                                 int'(bmft_pkg::ID_LOW))));
    rx_hold_req = 1'b1;
    send_random_items(120);

    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
